[design/kdef_pkg.sv]
// ----------------------------------------------------------------------------
// Key debounce event FIFO package
// Shared constants, codes and types for the debouncer and its event queue.
// ----------------------------------------------------------------------------
package kdef_pkg;

  localparam int NUM_KEYS   = 3;
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int NUM_SLOTS  = 2 * NUM_KEYS;
  localparam int SLOT_CNT_W = $clog2(NUM_SLOTS + 1);

  localparam int CMD_W     = 2;
  localparam int KEYS_W    = 3;
  localparam int KEY_W     = 2;
  localparam int CODE_W    = 4;
  localparam int FILTER_W  = 7;
  localparam int CNT_W     = 8;
  localparam int TIME_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [FILTER_W-1:0] FILTER_RESET = 7'd5;
  localparam logic [TIME_W-1:0]   LONG_RESET   = 16'd100;
  localparam logic [TIME_W-1:0]   REPEAT_RESET = 16'd0;
  localparam logic [CNT_W-1:0]    COUNT_RESET  = CNT_W'(FILTER_RESET / 2);

  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_TIME  = 2'd0,
    REG_LONG_TIME    = 2'd1,
    REG_REPEAT_SPEED = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    EVT_PRESS   = 2'd1,
    EVT_RELEASE = 2'd2,
    EVT_LONG    = 2'd3
  } evt_kind_e;

  typedef struct packed {
    logic [FILTER_W-1:0] filter_time;
    logic [TIME_W-1:0]   long_time;
    logic [TIME_W-1:0]   repeat_speed;
  } cfg_t;

  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] code;
  } slot_t;

  typedef struct packed {
    slot_t first;
    slot_t second;
    logic  down;
  } key_res_t;

  function automatic logic [CODE_W-1:0] evt_code(logic [KEY_W-1:0] key, evt_kind_e kind);
    logic [CODE_W-1:0] k4;
    k4 = {{(CODE_W-KEY_W){1'b0}}, key};
    return CODE_W'((k4 << 1) + k4 + {{(CODE_W-2){1'b0}}, kind});
  endfunction

endpackage

[design/kdef_in_if.sv]
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command beat with key levels and query.
// ----------------------------------------------------------------------------
interface kdef_in_if;
  logic                          valid;
  logic                          ready;
  logic [kdef_pkg::CMD_W-1:0]    command;
  logic [kdef_pkg::KEYS_W-1:0]   pressed_keys;
  logic [kdef_pkg::KEY_W-1:0]    query_key;

  modport source (output valid, command, pressed_keys, query_key, input ready);
  modport sink   (input valid, command, pressed_keys, query_key, output ready);
endinterface

[design/kdef_out_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result beat: event code and key state.
// ----------------------------------------------------------------------------
interface kdef_out_if;
  logic                          valid;
  logic                          ready;
  logic [kdef_pkg::CODE_W-1:0]   event_code;
  logic                          key_is_down;

  modport source (output valid, event_code, key_is_down, input ready);
  modport sink   (input valid, event_code, key_is_down, output ready);
endinterface

[design/kdef_key.sv]
// ----------------------------------------------------------------------------
// Single key debouncer
// Hysteresis counter, stable state, long-press and auto-repeat timers.
// ----------------------------------------------------------------------------
module kdef_key (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_i,
  input  logic                         level_i,
  input  logic [kdef_pkg::KEY_W-1:0]   key_idx_i,
  input  kdef_pkg::cfg_t               cfg_i,
  output kdef_pkg::key_res_t           res_o
);

  logic [kdef_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        stable_q, stable_d;
  logic [kdef_pkg::TIME_W-1:0] long_q, long_d;
  logic [kdef_pkg::TIME_W-1:0] rep_q, rep_d;
  logic [kdef_pkg::CNT_W-1:0]  ft;
  logic [kdef_pkg::CNT_W-1:0]  ceil;
  logic [kdef_pkg::TIME_W:0]   rep_inc;

  assign ft      = {1'b0, cfg_i.filter_time};
  assign ceil    = {cfg_i.filter_time, 1'b0};
  assign rep_inc = {1'b0, rep_q} + 17'd1;

  always_comb begin
    cnt_d    = cnt_q;
    stable_d = stable_q;
    long_d   = long_q;
    rep_d    = rep_q;
    res_o    = '0;
    if (tick_i) begin
      if (level_i) begin
        if (cnt_q < ft) begin
          cnt_d = ft;
        end else if (cnt_q < ceil) begin
          cnt_d = cnt_q + 8'd1;
        end else begin
          if (!stable_q) begin
            stable_d          = 1'b1;
            res_o.first.vld   = 1'b1;
            res_o.first.code  = kdef_pkg::evt_code(key_idx_i, kdef_pkg::EVT_PRESS);
          end
          if (cfg_i.long_time != '0) begin
            if (long_q != '1) begin
              long_d = long_q + 16'd1;
              if (long_d == cfg_i.long_time) begin
                res_o.second.vld  = 1'b1;
                res_o.second.code = kdef_pkg::evt_code(key_idx_i, kdef_pkg::EVT_LONG);
              end
            end
          end else if (cfg_i.repeat_speed != '0) begin
            if (rep_inc >= {1'b0, cfg_i.repeat_speed}) begin
              rep_d             = '0;
              res_o.second.vld  = 1'b1;
              res_o.second.code = kdef_pkg::evt_code(key_idx_i, kdef_pkg::EVT_PRESS);
            end else begin
              rep_d = rep_inc[kdef_pkg::TIME_W-1:0];
            end
          end
        end
      end else begin
        if (cnt_q > ft) begin
          cnt_d = ft;
        end else if (cnt_q != '0) begin
          cnt_d = cnt_q - 8'd1;
        end else if (stable_q) begin
          stable_d         = 1'b0;
          res_o.first.vld  = 1'b1;
          res_o.first.code = kdef_pkg::evt_code(key_idx_i, kdef_pkg::EVT_RELEASE);
        end
        rep_d  = '0;
        long_d = '0;
      end
    end
    res_o.down = stable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= kdef_pkg::COUNT_RESET;
      stable_q <= 1'b0;
      long_q   <= '0;
      rep_q    <= '0;
    end else begin
      cnt_q    <= cnt_d;
      stable_q <= stable_d;
      long_q   <= long_d;
      rep_q    <= rep_d;
    end
  end

endmodule

[design/kdef_fifo.sv]
// ----------------------------------------------------------------------------
// Event ring FIFO
// Takes several event codes per beat in slot order; pops one code per read.
// ----------------------------------------------------------------------------
module kdef_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kdef_pkg::slot_t               wr_slots_i [kdef_pkg::NUM_SLOTS],
  input  logic                          rd_en_i,
  input  logic                          clr_en_i,
  output logic [kdef_pkg::CODE_W-1:0]   rd_code_o
);

  logic [kdef_pkg::CODE_W-1:0]     mem_q [kdef_pkg::FIFO_DEPTH];
  logic [kdef_pkg::PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [kdef_pkg::PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [kdef_pkg::PTR_W-1:0]      wr_addr [kdef_pkg::NUM_SLOTS];
  logic [kdef_pkg::SLOT_CNT_W-1:0] wr_cnt;
  logic                            empty;

  assign empty = (rd_ptr_q == wr_ptr_q);

  always_comb begin
    wr_cnt = '0;
    for (int i = 0; i < kdef_pkg::NUM_SLOTS; i++) begin
      wr_addr[i] = wr_ptr_q + kdef_pkg::PTR_W'(wr_cnt);
      wr_cnt     = wr_cnt + kdef_pkg::SLOT_CNT_W'(wr_slots_i[i].vld);
    end
    wr_ptr_d = wr_ptr_q + kdef_pkg::PTR_W'(wr_cnt);
  end

  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    rd_code_o = '0;
    if (clr_en_i) begin
      rd_ptr_d = wr_ptr_q;
    end else if (rd_en_i && !empty) begin
      rd_ptr_d  = rd_ptr_q + 1'b1;
      rd_code_o = mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < kdef_pkg::NUM_SLOTS; i++) begin
      if (wr_slots_i[i].vld) begin
        mem_q[wr_addr[i]] <= wr_slots_i[i].code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_en_i |=> rd_ptr_q == wr_ptr_q)
    else $error("FIFO not empty after clear");

  a_read_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && !clr_en_i && !empty |=>
      rd_ptr_q == kdef_pkg::PTR_W'($past(rd_ptr_q) + 1'b1))
    else $error("Read pointer did not advance on a pop");

  a_wr_ptr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cnt == '0 |=> $stable(wr_ptr_q))
    else $error("Write pointer moved without a write");

endmodule

[design/key_debounce_event_fifo.sv]
// ----------------------------------------------------------------------------
// Key debounce event FIFO
// Debounces three keys and queues press, release, long-press and repeat events.
// ----------------------------------------------------------------------------
// Usage: each beat on in_i carries a command. A scan beat advances every key's
// debounce counter by one tick using pressed_keys and may queue up to two
// events per key. A read beat pops one event code, or returns 0 when the
// queue is empty. A clear beat empties the queue. Every beat yields exactly
// one result beat on out_o with the event code (0 unless a read popped one)
// and the debounced state of query_key after the command.
// A beat is held in the input register and then in the result register that
// drives out_o; one beat is accepted every cycle while out_o takes results,
// as the input register and the result register each hold one beat and all
// keys update in parallel in a single pass.
// When out_o stalls, the result register holds and the input register can
// still take one more beat before ready drops.
// Configuration writes through cfg_we_i take effect on the next beat; the
// user makes them only while no beat is in flight, not enforced by the block.
// Reset restores the default register values, sets all keys released and
// empties the queue; the block accepts beats right after reset.
// ----------------------------------------------------------------------------
module key_debounce_event_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  kdef_in_if.sink                          in_i,
  kdef_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [kdef_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kdef_pkg::CFG_W-1:0]       cfg_data_i
);

  kdef_pkg::cfg_t                  cfg_q;
  logic                            s1_valid_q;
  logic [kdef_pkg::CMD_W-1:0]      s1_cmd_q;
  logic [kdef_pkg::KEYS_W-1:0]     s1_keys_q;
  logic [kdef_pkg::KEY_W-1:0]      s1_query_q;
  logic                            out_valid_q;
  logic [kdef_pkg::CODE_W-1:0]     out_code_q;
  logic                            out_down_q;
  logic                            s2_adv;
  logic                            in_acc;
  logic                            tick;
  logic                            rd_en;
  logic                            clr_en;
  logic                            down;
  logic [kdef_pkg::CODE_W-1:0]     rd_code;
  kdef_pkg::key_res_t              key_res [kdef_pkg::NUM_KEYS];
  kdef_pkg::slot_t                 slots [kdef_pkg::NUM_SLOTS];

  assign s2_adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s2_adv;
  assign in_acc      = in_i.valid && in_i.ready;

  always_comb begin
    tick   = 1'b0;
    rd_en  = 1'b0;
    clr_en = 1'b0;
    case (s1_cmd_q)
      kdef_pkg::CMD_SCAN:  tick   = s2_adv;
      kdef_pkg::CMD_READ:  rd_en  = s2_adv;
      kdef_pkg::CMD_CLEAR: clr_en = s2_adv;
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < kdef_pkg::NUM_KEYS; k++) begin : g_key
    kdef_key u_key (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tick_i    (tick),
      .level_i   (s1_keys_q[k]),
      .key_idx_i (kdef_pkg::KEY_W'(k)),
      .cfg_i     (cfg_q),
      .res_o     (key_res[k])
    );
    assign slots[2*k]   = key_res[k].first;
    assign slots[2*k+1] = key_res[k].second;
  end

  kdef_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_slots_i (slots),
    .rd_en_i    (rd_en),
    .clr_en_i   (clr_en),
    .rd_code_o  (rd_code)
  );

  always_comb begin
    down = 1'b0;
    for (int k = 0; k < kdef_pkg::NUM_KEYS; k++) begin
      if (s1_query_q == kdef_pkg::KEY_W'(k)) begin
        down = key_res[k].down;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_time  <= kdef_pkg::FILTER_RESET;
      cfg_q.long_time    <= kdef_pkg::LONG_RESET;
      cfg_q.repeat_speed <= kdef_pkg::REPEAT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kdef_pkg::REG_FILTER_TIME:  cfg_q.filter_time  <= cfg_data_i[kdef_pkg::FILTER_W-1:0];
        kdef_pkg::REG_LONG_TIME:    cfg_q.long_time    <= cfg_data_i;
        kdef_pkg::REG_REPEAT_SPEED: cfg_q.repeat_speed <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= in_i.command;
      s1_keys_q  <= in_i.pressed_keys;
      s1_query_q <= in_i.query_key;
    end
    if (s2_adv) begin
      out_code_q <= rd_code;
      out_down_q <= down;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_code  = out_code_q;
  assign out_o.key_is_down = out_down_q;

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_adv |=> out_valid_q)
    else $error("Result register not loaded after advance");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("Input register not loaded after accept");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_adv |=> s1_valid_q && $stable(s1_cmd_q))
    else $error("Stalled input register lost its beat");

endmodule
